// ----- hdl/ros_pkg.sv -----
package ros_pkg;
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  localparam logic [2:0] KIND_RANK = 3'd0;
  localparam logic [2:0] KIND_KTH  = 3'd1;
  localparam logic [2:0] KIND_SET  = 3'd2;
  localparam logic [2:0] KIND_PRED = 3'd3;
  localparam logic [2:0] KIND_SUCC = 3'd4;

  localparam logic [31:0] TOP_SENT = 32'h7FFF_FFFF;
  localparam logic [31:0] BOT_SENT = 32'h8000_0001;
  localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] left;
    logic [10:0] right;
    logic [10:0] position;
    logic signed [31:0] value;
    logic [10:0] order;
  } req_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic               error;
  } rsp_t;
endpackage

// ----- hdl/ros_if.sv -----
interface ros_req_if import ros_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ros_rsp_if import ros_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/ros_store.sv -----
module ros_store import ros_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  output logic          rd_vld,
  output logic          busy
);
  // each entry holds its valid bit on top of the value
  logic [32:0]    mem [DEPTH];
  logic [32:0]    rd_q;
  logic [AW-1:0]  clr_addr_r;
  logic           clr_r;
  logic           we;
  logic [AW-1:0]  wa;
  logic [32:0]    wd;

  assign busy = clr_r;
  assign we   = clr_r || wr_en;
  assign wa   = clr_r ? clr_addr_r : wr_addr;
  assign wd   = clr_r ? 33'd0 : {1'b1, wr_data};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // sweep every entry once after reset to drop the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  assign rd_data = rd_q[31:0];
  assign rd_vld  = rd_q[32];
endmodule

// ----- hdl/range_order_statistics.sv -----
// Channel | Dir | Payload
// in_ch   | in  | kind, left, right, position, value, order
// out_ch  | out | answer, error
// After reset the store clears its 1024 entries, one per cycle, with in_ch.ready low.
// Set and unused kinds are taken in ST_IDLE without leaving it. Rank, predecessor, successor read n = right-left+1
// entries in ST_SCAN, then pass through ST_LAST and ST_DONE before the next transaction is accepted.
// Kth runs 33 scans (valid count, then one per result bit).
// A bad range skips the scan and goes straight to ST_DONE; a bad order ends after the count scan.
// A held result stalls only the next result; the block keeps taking input until that result waits in ST_DONE.
module range_order_statistics import ros_pkg::*; (
  input logic clk,
  input logic rst_n,
  ros_req_if.sink   in_ch,
  ros_rsp_if.source out_ch
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]  st_r, st_nxt;
  req_t        req_r;
  logic [AW-1:0] addr_r, lo_r, hi_r;
  logic        tail_r;           // a read is in flight
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] best_r, sel_r, lim_r;
  logic        found_r, first_r;  // first: kth total pass
  logic        bad_r;
  logic [4:0]  bit_r;
  logic        ov_r, ov_nxt;
  rsp_t        rsp_r;

  logic        wr_en, rd_en, rd_vld, busy, accept, is_query;
  logic [31:0] rd_data, bv, key, sel_new;
  logic        range_bad, hit, pred_hit, succ_hit, order_bad, kth_more, rescan, emit;
  logic [AW-1:0] wa;
  logic [10:0] lm1, rm1, pm1;

  assign lm1 = in_ch.payload.left - 11'd1;
  assign rm1 = in_ch.payload.right - 11'd1;
  assign pm1 = in_ch.payload.position - 11'd1;
  assign wa = pm1[AW-1:0];
  assign range_bad = (in_ch.payload.left == 11'd0) ||
                     ({21'd0, in_ch.payload.right} > DEPTH) ||
                     (in_ch.payload.left > in_ch.payload.right);
  assign is_query = in_ch.payload.kind == KIND_RANK || in_ch.payload.kind == KIND_KTH ||
                    in_ch.payload.kind == KIND_PRED || in_ch.payload.kind == KIND_SUCC;

  assign in_ch.ready = (st_r == ST_IDLE) && !busy;
  assign accept = in_ch.valid && in_ch.ready;
  assign wr_en = accept && in_ch.payload.kind == KIND_SET &&
                 in_ch.payload.position != 11'd0 &&
                 {21'd0, in_ch.payload.position} <= DEPTH;
  assign rd_en = (st_r == ST_SCAN);

  ros_store u_store (
    .clk, .rst_n, .wr_en, .wr_addr(wa), .wr_data(in_ch.payload.value),
    .rd_en, .rd_addr(addr_r), .rd_data, .rd_vld, .busy
  );

  assign bv  = rd_data ^ SIGN_BIAS;
  assign key = req_r.value ^ SIGN_BIAS;
  assign hit = tail_r && rd_vld;
  assign pred_hit = hit && req_r.kind == KIND_PRED && bv < key && (!found_r || bv > best_r);
  assign succ_hit = hit && req_r.kind == KIND_SUCC && bv > key && (!found_r || bv < best_r);

  // kth: keep the tested bit when fewer than order entries lie below it
  assign sel_new   = (cnt_r < req_r.order) ? lim_r : sel_r;
  assign order_bad = (req_r.order == 11'd0) || (req_r.order > cnt_r);
  assign kth_more  = req_r.kind == KIND_KTH && !bad_r &&
                     (first_r ? !order_bad : (bit_r != 5'd0));
  assign rescan    = (st_r == ST_DONE) && kth_more;
  assign emit      = (st_r == ST_DONE) && !kth_more && (!ov_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept && is_query) st_nxt = range_bad ? ST_DONE : ST_SCAN;
      ST_SCAN: if (addr_r == hi_r) st_nxt = ST_LAST;
      ST_LAST: st_nxt = ST_DONE;
      ST_DONE: begin
        if (kth_more) st_nxt = ST_SCAN;
        else if (emit) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (hit) begin
      if (req_r.kind == KIND_RANK && bv < key) cnt_nxt = cnt_r + 1'b1;
      if (req_r.kind == KIND_KTH && (first_r || bv < lim_r)) cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    if (emit) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ov_r   <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      tail_r <= rd_en;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_ch.payload;
      lo_r    <= lm1[AW-1:0];
      hi_r    <= rm1[AW-1:0];
      bad_r   <= range_bad;
      first_r <= 1'b1;
      bit_r   <= 5'd31;
      sel_r   <= '0;
      lim_r   <= '0;
    end else if (rescan) begin
      first_r <= 1'b0;
      if (first_r) begin
        lim_r <= SIGN_BIAS;  // test the top bit first
      end else begin
        sel_r <= sel_new;
        bit_r <= bit_r - 5'd1;
        lim_r <= sel_new | (32'd1 << (bit_r - 5'd1));
      end
    end
    if (accept || rescan) begin
      addr_r  <= accept ? lm1[AW-1:0] : lo_r;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (st_r == ST_SCAN && addr_r != hi_r) addr_r <= addr_r + 1'b1;
      cnt_r <= cnt_nxt;
      if (pred_hit || succ_hit) begin
        best_r  <= bv;
        found_r <= 1'b1;
      end
    end
    if (emit) begin
      if (bad_r) begin
        rsp_r.answer <= 32'd0;
        rsp_r.error  <= 1'b1;
      end else begin
        case (req_r.kind)
          KIND_RANK: begin
            rsp_r.answer <= 32'(cnt_r) + 32'd1;
            rsp_r.error  <= 1'b0;
          end
          KIND_KTH: begin
            rsp_r.answer <= first_r ? 32'd0 : (sel_new ^ SIGN_BIAS);
            rsp_r.error  <= first_r;
          end
          KIND_PRED: begin
            rsp_r.answer <= found_r ? (best_r ^ SIGN_BIAS) : BOT_SENT;
            rsp_r.error  <= 1'b0;
          end
          default: begin
            rsp_r.answer <= found_r ? (best_r ^ SIGN_BIAS) : TOP_SENT;
            rsp_r.error  <= 1'b0;
          end
        endcase
      end
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.payload = rsp_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ch.ready) else $error("accept while busy");
  a_read_tail: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> tail_r) else $error("read tail lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(rsp_r)) else $error("result dropped");
  a_clear_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !wr_en) else $error("write during clear");
endmodule
